### src/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and codes for the reader-writer lock arbiter.
// ----------------------------------------------------------------------------
package rwl_pkg;

  localparam int TASK_W = 8;
  localparam int KIND_W = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_GRANTED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DENIED    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REL_ERROR = 3'd4;
  localparam logic [KIND_W-1:0] KIND_WOKEN     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd6;

  // command codes passed from front to back
  localparam logic [1:0] CMD_ACQ_READ  = 2'd0;
  localparam logic [1:0] CMD_ACQ_WRITE = 2'd1;
  localparam logic [1:0] CMD_RELEASE   = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [TASK_W-1:0] task_id;
    logic              no_wait;
  } cmd_t;

endpackage

### src/reader_writer_lock_fifo_waiters.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_fifo_waiters
// Reader-writer lock arbiter with a FIFO of waiting tasks.
// ----------------------------------------------------------------------------
// Request channel: a beat is taken at a rising edge with start high and busy
// low. busy rises only while the two-entry command queue is full.
// Result channel: each result beat sits on kind/task_id_res/last for one
// cycle with done high; the receiver cannot stall, so beats are never held.
// last marks the final beat caused by one request.
// Result path: an acquire or a release of an unheld lock is written into the
// command queue and strobes its beat once the idle back end takes it; a
// release of a held lock is taken into S_CHK, which strobes its released beat.
// Sequencing, set by the back-end sequencer: an acquire or a release of an
// unheld lock is done in S_IDLE; a release of a held lock then passes S_CHK,
// which stays for each further woken reader, and S_FIN when a writer wakes.
// The front keeps taking beats meanwhile until the command queue fills.
// The head waiter entry is read from the waiter memory into a register ahead
// of each wake decision.
// Reset (rst, synchronous): lock free, waiter queue and command queue empty,
// no result pending. The waiter memory is not cleared.
// ----------------------------------------------------------------------------
module reader_writer_lock_fifo_waiters #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8,
  parameter int READER_LIMIT = 255
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  logic [rwl_pkg::TASK_W-1:0] task_id,
  input  logic                       want_write,
  input  logic                       no_wait,
  output logic                       done,
  output logic [rwl_pkg::KIND_W-1:0] kind,
  output logic [rwl_pkg::TASK_W-1:0] task_id_res,
  output logic                       last
);

  logic          full;
  logic          push;
  logic          not_empty;
  logic          cmd_pop;
  rwl_pkg::cmd_t front_cmd;
  rwl_pkg::cmd_t head_cmd;

  rwl_front #(
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_front (
    .start      (start),
    .full       (full),
    .operation  (operation),
    .task_id    (task_id),
    .want_write (want_write),
    .no_wait    (no_wait),
    .busy       (busy),
    .push       (push),
    .cmd        (front_cmd)
  );

  rwl_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .pop       (cmd_pop),
    .full      (full),
    .not_empty (not_empty),
    .head_cmd  (head_cmd)
  );

  rwl_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS),
    .READER_LIMIT (READER_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (not_empty),
    .cmd         (head_cmd),
    .cmd_pop     (cmd_pop),
    .done        (done),
    .kind        (kind),
    .task_id_res (task_id_res),
    .last        (last)
  );

endmodule

### src/rwl_front.sv
// ----------------------------------------------------------------------------
// rwl_front
// Accepts request beats, classifies them into lock commands and masks the
// task id to its significant bits.
// ----------------------------------------------------------------------------
module rwl_front #(
  parameter int TASK_ID_BITS = 8
) (
  input  logic                      start,
  input  logic                      full,
  input  logic                      operation,
  input  logic [rwl_pkg::TASK_W-1:0] task_id,
  input  logic                      want_write,
  input  logic                      no_wait,
  output logic                      busy,
  output logic                      push,
  output rwl_pkg::cmd_t             cmd
);

  localparam logic [rwl_pkg::TASK_W-1:0] TASK_MASK =
    (TASK_ID_BITS >= rwl_pkg::TASK_W) ? {rwl_pkg::TASK_W{1'b1}} :
    rwl_pkg::TASK_W'((1 << TASK_ID_BITS) - 1);

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    if (operation) begin
      cmd.op = rwl_pkg::CMD_RELEASE;
    end else if (want_write) begin
      cmd.op = rwl_pkg::CMD_ACQ_WRITE;
    end else begin
      cmd.op = rwl_pkg::CMD_ACQ_READ;
    end
    cmd.task_id = task_id & TASK_MASK;
    cmd.no_wait = no_wait;
  end

endmodule

### src/rwl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rwl_cmd_fifo
// Two-entry command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rwl_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rwl_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output rwl_pkg::cmd_t head_cmd
);

  rwl_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/rwl_back.sv
// ----------------------------------------------------------------------------
// rwl_back
// Carries out lock commands: holds the lock state and the waiter queue,
// and issues at most one result beat per cycle, waking waiters after a release.
// ----------------------------------------------------------------------------
module rwl_back #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8,
  parameter int READER_LIMIT = 255
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  rwl_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        done,
  output logic [rwl_pkg::KIND_W-1:0]  kind,
  output logic [rwl_pkg::TASK_W-1:0]  task_id_res,
  output logic                        last
);

  localparam int TW  = (TASK_ID_BITS < rwl_pkg::TASK_W) ? TASK_ID_BITS : rwl_pkg::TASK_W;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int RCW = $clog2(READER_LIMIT + 1);
  localparam logic [RCW-1:0] RD_LIMIT = RCW'(READER_LIMIT);
  localparam logic [CW-1:0]  Q_FULL   = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]  PTR_MAX  = PW'(QUEUE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]     state;
  logic           writer_held;
  logic [RCW-1:0] reader_count;
  logic [PW-1:0]  queue_head;
  logic [PW-1:0]  queue_head_next;
  logic [PW-1:0]  queue_tail;
  logic [CW-1:0]  queue_count;

  // waiter store: {is_write, task}
  logic [TW:0]    wait_mem [QUEUE_DEPTH];
  logic [TW:0]    head_entry;
  logic           mem_we;

  logic [rwl_pkg::KIND_W-1:0] pend_kind;
  logic [rwl_pkg::TASK_W-1:0] pend_task;

  logic is_acq;
  logic acq_wr;
  logic blocked;
  logic head_wr;
  logic wake_ok;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign is_acq  = cmd.op inside {rwl_pkg::CMD_ACQ_READ, rwl_pkg::CMD_ACQ_WRITE};
  assign acq_wr  = (cmd.op == rwl_pkg::CMD_ACQ_WRITE);
  assign blocked = writer_held || (acq_wr && reader_count != '0) ||
                   (!acq_wr && !(reader_count < RD_LIMIT));
  assign mem_we  = cmd_pop && is_acq && blocked && !cmd.no_wait && (queue_count != Q_FULL);

  assign head_wr = head_entry[TW];
  assign wake_ok = (queue_count != '0) && !writer_held &&
                   (head_wr ? (reader_count == '0) : (reader_count < RD_LIMIT));

  always_comb begin
    if (state == S_CHK && wake_ok) begin
      queue_head_next = ptr_inc(queue_head);
    end else begin
      queue_head_next = queue_head;
    end
  end

  // head entry is registered ahead of the wake check
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wait_mem[queue_tail] <= {acq_wr, cmd.task_id[TW-1:0]};
    end
    head_entry <= wait_mem[queue_head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      writer_held  <= 1'b0;
      reader_count <= '0;
      queue_head   <= '0;
      queue_tail   <= '0;
      queue_count  <= '0;
      done         <= 1'b0;
    end else begin
      done       <= 1'b0;
      queue_head <= queue_head_next;
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            task_id_res <= cmd.task_id;
            if (is_acq) begin
              done <= 1'b1;
              last <= 1'b1;
              if (!blocked) begin
                kind <= rwl_pkg::KIND_GRANTED;
                if (acq_wr) begin
                  writer_held <= 1'b1;
                end else begin
                  reader_count <= reader_count + 1'b1;
                end
              end else if (cmd.no_wait) begin
                kind <= rwl_pkg::KIND_DENIED;
              end else if (queue_count == Q_FULL) begin
                kind <= rwl_pkg::KIND_FULL;
              end else begin
                kind        <= rwl_pkg::KIND_QUEUED;
                queue_tail  <= ptr_inc(queue_tail);
                queue_count <= queue_count + 1'b1;
              end
            end else if (!writer_held && reader_count == '0) begin
              done <= 1'b1;
              last <= 1'b1;
              kind <= rwl_pkg::KIND_REL_ERROR;
            end else begin
              if (writer_held) begin
                writer_held <= 1'b0;
              end else begin
                reader_count <= reader_count - 1'b1;
              end
              pend_kind <= rwl_pkg::KIND_RELEASED;
              pend_task <= cmd.task_id;
              state     <= S_CHK;
            end
          end
        end
        S_CHK: begin
          // emit the held beat; last unless another waiter wakes behind it
          done        <= 1'b1;
          kind        <= pend_kind;
          task_id_res <= pend_task;
          last        <= !wake_ok;
          if (wake_ok) begin
            pend_kind   <= rwl_pkg::KIND_WOKEN;
            pend_task   <= rwl_pkg::TASK_W'(head_entry[TW-1:0]);
            queue_count <= queue_count - 1'b1;
            if (head_wr) begin
              writer_held <= 1'b1;
              state       <= S_FIN;
            end else begin
              reader_count <= reader_count + 1'b1;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          done        <= 1'b1;
          kind        <= pend_kind;
          task_id_res <= pend_task;
          last        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/rwl_checker.sv
// ----------------------------------------------------------------------------
// rwl_checker
// Port-level checks on the result sequence of the lock arbiter.
// ----------------------------------------------------------------------------
module rwl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       done,
  input logic [rwl_pkg::KIND_W-1:0] kind,
  input logic                       last
);

  // no result beat in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result beat right after reset");

  // a non-final beat is always followed by another beat
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> done)
    else $error("result burst broken");

  // the beat after a non-final one is a woken waiter
  a_burst_woken: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> (kind == rwl_pkg::KIND_WOKEN))
    else $error("non-woken beat inside a wake burst");

  // only released and woken beats can be non-final
  a_single_kinds: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> (kind == rwl_pkg::KIND_RELEASED || kind == rwl_pkg::KIND_WOKEN))
    else $error("single-beat kind marked non-final");

endmodule

bind reader_writer_lock_fifo_waiters rwl_checker u_rwl_checker (
  .clk  (clk),
  .rst  (rst),
  .done (done),
  .kind (kind),
  .last (last)
);
